// ----- hw/rtl/rclm_pkg.sv -----
`default_nettype none
package rclm_pkg;

  // Slot indexes and result slots are four bits wide, which covers up to 16 slots.
  localparam int SLOT_W    = 4;
  localparam int SLOTS_DEF = 10;

  localparam int CODE_W   = 32;
  localparam int BITS_W   = 6;
  localparam int BUCKET_W = 8;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 4;
  localparam int TICK_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Register reset values.
  localparam logic [BITS_W-1:0]   MIN_BITS_RST  = BITS_W'(16);
  localparam logic [BITS_W-1:0]   MAX_BITS_RST  = BITS_W'(32);
  localparam logic [BUCKET_W-1:0] TOL_RST       = BUCKET_W'(3);
  localparam logic [TICK_W-1:0]   TIMEOUT_RST   = TICK_W'(30000);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd3;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_FRAME  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNBIND = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_MATCHED   = 4'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 4'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_LEARNED   = 4'd3;
  localparam logic [STATUS_W-1:0] ST_ALREADY   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 4'd5;
  localparam logic [STATUS_W-1:0] ST_STARTED   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 4'd7;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 4'd8;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 4'd9;
  localparam logic [STATUS_W-1:0] ST_UNBOUND   = 4'd10;
  localparam logic [STATUS_W-1:0] ST_NOTHING   = 4'd11;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [CODE_W-1:0]   code;
    logic [BITS_W-1:0]   bit_count;
    logic [BUCKET_W-1:0] pulse_bucket;
    logic [SLOT_W-1:0]   slot_index;
    logic                any_slot;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   result_slot;
    logic                learn_active;
    logic [SLOT_W-1:0]   assigned_count;
    logic [SLOT_W-1:0]   bound_count;
  } out_item_t;

  // Search record that travels down the row of slot cells.
  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [BITS_W-1:0]   bits;
    logic [BUCKET_W-1:0] bucket;
    logic [SLOT_W-1:0]   sel_idx;
    logic                skip_en;
    logic                hit;
    logic [SLOT_W-1:0]   hit_idx;
    logic                free;
    logic [SLOT_W-1:0]   free_idx;
    logic                sel_assigned;
    logic                sel_bound;
  } probe_t;

  // Slot update broadcast to all cells.
  typedef struct packed {
    logic                en;
    logic                bound;
    logic [SLOT_W-1:0]   idx;
    logic [CODE_W-1:0]   code;
    logic [BITS_W-1:0]   bits;
    logic [BUCKET_W-1:0] bucket;
  } slot_wr_t;

endpackage
`default_nettype wire

// ----- hw/rtl/remote_code_learn_match_table.sv -----
// Remote code learn and match table.
// Input items (frames, learn start, learn cancel, unbind, timer tick) arrive on a
// valid/stall channel; each accepted item yields exactly one result item on the
// output valid/stall channel. Configuration registers (bit-count limits, bucket
// tolerance, learn timeout) are written over a valid/ready port that is always
// ready; write them only while the block is idle.
// Every item is searched through a row of SLOTS slot cells, one cell per cycle,
// and a new item is taken only after the previous one has finished its search
// and its result has been written to the output register.
// The length of the cell row sets how long each search takes.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the finished search holds its result until the
// output register frees, and no state is changed before then.
// Reset clears all slot marks, the learn session and the configuration
// registers to their defaults; the table is usable as soon as reset is released.
`default_nettype none
module remote_code_learn_match_table #(
  parameter int SLOTS = rclm_pkg::SLOTS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire rclm_pkg::in_item_t                 in_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output rclm_pkg::out_item_t                     out_item_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [rclm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [rclm_pkg::CFG_DAT_W-1:0]     cfg_data_i
);
  import rclm_pkg::*;

  // Search record at every point of the cell row; entry 0 comes from control.
  probe_t              chain [SLOTS+1];
  slot_wr_t            wr;
  logic [BUCKET_W-1:0] tol;

  rclm_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tol_o       (tol),
    .probe_o     (chain[0]),
    .probe_i     (chain[SLOTS]),
    .wr_o        (wr)
  );

  // Each cell checks its slot against the passing record and hands it on.
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    rclm_cell #(
      .IDX(k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tol_i   (tol),
      .wr_i    (wr),
      .probe_i (chain[k]),
      .probe_o (chain[k+1])
    );
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rclm_cell.sv -----
`default_nettype none
module rclm_cell #(
  parameter int IDX = 0
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [rclm_pkg::BUCKET_W-1:0]     tol_i,
  input  wire rclm_pkg::slot_wr_t                wr_i,
  input  wire rclm_pkg::probe_t                  probe_i,
  output rclm_pkg::probe_t                       probe_o
);
  import rclm_pkg::*;

  localparam logic [SLOT_W-1:0] MyIdx = SLOT_W'(IDX);

  logic                assigned_q, bound_q;
  logic [CODE_W-1:0]   code_q;
  logic [BITS_W-1:0]   bits_q;
  logic [BUCKET_W-1:0] bucket_q;
  logic [BUCKET_W-1:0] diff;
  logic                match;
  logic                wr_here;
  probe_t              probe_d, probe_q;

  assign wr_here = wr_i.en && (wr_i.idx == MyIdx);

  always_comb begin
    diff = (bucket_q > probe_i.bucket) ? bucket_q - probe_i.bucket
                                       : probe_i.bucket - bucket_q;
    match = bound_q && (code_q == probe_i.code) && (bits_q == probe_i.bits) &&
            (diff <= tol_i) && !(probe_i.skip_en && (probe_i.sel_idx == MyIdx));
    probe_d = probe_i;
    if (match && !probe_i.hit) begin
      probe_d.hit     = 1'b1;
      probe_d.hit_idx = MyIdx;
    end
    if (!assigned_q && !probe_i.free) begin
      probe_d.free     = 1'b1;
      probe_d.free_idx = MyIdx;
    end
    if (probe_i.sel_idx == MyIdx) begin
      probe_d.sel_assigned = assigned_q;
      probe_d.sel_bound    = bound_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assigned_q <= 1'b0;
      bound_q    <= 1'b0;
    end else if (wr_here) begin
      bound_q <= wr_i.bound;
      if (wr_i.bound) begin
        assigned_q <= 1'b1;
      end
    end
  end

  // Slot contents are only looked at while the bound mark is set.
  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
    if (wr_here) begin
      code_q   <= wr_i.code;
      bits_q   <= wr_i.bits;
      bucket_q <= wr_i.bucket;
    end
  end

  assign probe_o = probe_q;

endmodule
`default_nettype wire

// ----- hw/rtl/rclm_ctrl.sv -----
`default_nettype none
module rclm_ctrl #(
  parameter int SLOTS = rclm_pkg::SLOTS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire rclm_pkg::in_item_t                 in_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output rclm_pkg::out_item_t                     out_item_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [rclm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [rclm_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  output logic [rclm_pkg::BUCKET_W-1:0]           tol_o,
  output rclm_pkg::probe_t                        probe_o,
  input  wire rclm_pkg::probe_t                   probe_i,
  output rclm_pkg::slot_wr_t                      wr_o
);
  import rclm_pkg::*;

  localparam int CntW = $clog2(SLOTS + 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e               state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  in_item_t             item_q;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;
  logic                 learning_q, learning_d;
  logic                 tgt_any_q, tgt_any_d;
  logic [SLOT_W-1:0]    tgt_q, tgt_d;
  logic [TICK_W-1:0]    elapsed_q, elapsed_d;
  logic [CntW-1:0]      nassigned_q, nassigned_d;
  logic [CntW-1:0]      nbound_q, nbound_d;
  logic [BITS_W-1:0]    min_bits_q, max_bits_q;
  logic [BUCKET_W-1:0]  tol_q;
  logic [TICK_W-1:0]    timeout_q;
  logic                 accept, scan_done, commit;
  logic [TICK_W-1:0]    elapsed_inc;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    rslot;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign scan_done   = (state_q == S_SCAN) && (cnt_q == CntW'(SLOTS));
  assign commit      = scan_done && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign tol_o       = tol_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Search record entering the first cell.
  always_comb begin
    probe_o          = '0;
    probe_o.code     = item_q.code;
    probe_o.bits     = item_q.bit_count;
    probe_o.bucket   = item_q.pulse_bucket;
    if (item_q.command == CMD_FRAME) begin
      probe_o.sel_idx = tgt_q;
      probe_o.skip_en = learning_q && !tgt_any_q;
    end else begin
      probe_o.sel_idx = item_q.slot_index;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    learning_d  = learning_q;
    tgt_any_d   = tgt_any_q;
    tgt_d       = tgt_q;
    elapsed_d   = elapsed_q;
    nassigned_d = nassigned_q;
    nbound_d    = nbound_q;
    wr_o        = '0;
    wr_o.code   = item_q.code;
    wr_o.bits   = item_q.bit_count;
    wr_o.bucket = item_q.pulse_bucket;
    status      = ST_NOTHING;
    rslot       = '0;
    elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TICK_W'(1);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (item_q.command)
      CMD_FRAME: begin
        if (item_q.bit_count < min_bits_q || item_q.bit_count > max_bits_q ||
            item_q.code == '0) begin
          status = ST_INVALID;
        end else if (learning_q) begin
          if (tgt_any_q && !probe_i.free) begin
            status     = ST_EXHAUSTED;
            learning_d = 1'b0;
          end else if (probe_i.hit) begin
            status = ST_ALREADY;
          end else begin
            status      = ST_LEARNED;
            learning_d  = 1'b0;
            rslot       = tgt_any_q ? probe_i.free_idx : tgt_q;
            wr_o.en     = commit;
            wr_o.bound  = 1'b1;
            wr_o.idx    = rslot;
            // A free target is neither assigned nor bound yet.
            if (tgt_any_q || !probe_i.sel_assigned) begin
              nassigned_d = nassigned_q + CntW'(1);
            end
            if (tgt_any_q || !probe_i.sel_bound) begin
              nbound_d = nbound_q + CntW'(1);
            end
          end
        end else if (probe_i.hit) begin
          status = ST_MATCHED;
          rslot  = probe_i.hit_idx;
        end else begin
          status = ST_NO_MATCH;
        end
      end
      CMD_START: begin
        if (item_q.any_slot) begin
          status = probe_i.free ? ST_STARTED : ST_EXHAUSTED;
        end else begin
          status = probe_i.sel_assigned ? ST_STARTED : ST_UNKNOWN;
        end
        if (status == ST_STARTED) begin
          learning_d = 1'b1;
          tgt_any_d  = item_q.any_slot;
          tgt_d      = item_q.any_slot ? '0 : item_q.slot_index;
          elapsed_d  = '0;
        end
      end
      CMD_CANCEL: begin
        learning_d = 1'b0;
        status     = ST_CANCELLED;
      end
      CMD_UNBIND: begin
        if (probe_i.sel_assigned) begin
          status     = ST_UNBOUND;
          wr_o.en    = commit;
          wr_o.bound = 1'b0;
          wr_o.idx   = item_q.slot_index;
          if (probe_i.sel_bound) begin
            nbound_d = nbound_q - CntW'(1);
          end
        end else begin
          status = ST_UNKNOWN;
        end
      end
      CMD_TICK: begin
        if (learning_q) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= timeout_q) begin
            learning_d = 1'b0;
            status     = ST_TIMEOUT;
          end
        end
      end
      default: begin
        status = ST_NOTHING;
      end
    endcase

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          cnt_d   = '0;
        end
      end
      S_SCAN: begin
        if (!scan_done) begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (commit) begin
      state_d                  = S_IDLE;
      out_valid_d              = 1'b1;
      out_d.status             = status;
      out_d.result_slot        = rslot;
      out_d.learn_active       = learning_d;
      out_d.assigned_count     = SLOT_W'(nassigned_d);
      out_d.bound_count        = SLOT_W'(nbound_d);
    end else begin
      learning_d  = learning_q;
      tgt_any_d   = tgt_any_q;
      tgt_d       = tgt_q;
      elapsed_d   = elapsed_q;
      nassigned_d = nassigned_q;
      nbound_d    = nbound_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      learning_q  <= 1'b0;
      tgt_any_q   <= 1'b0;
      tgt_q       <= '0;
      elapsed_q   <= '0;
      nassigned_q <= '0;
      nbound_q    <= '0;
      min_bits_q  <= MIN_BITS_RST;
      max_bits_q  <= MAX_BITS_RST;
      tol_q       <= TOL_RST;
      timeout_q   <= TIMEOUT_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      learning_q  <= learning_d;
      tgt_any_q   <= tgt_any_d;
      tgt_q       <= tgt_d;
      elapsed_q   <= elapsed_d;
      nassigned_q <= nassigned_d;
      nbound_q    <= nbound_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_MIN_BITS: min_bits_q <= cfg_data_i[BITS_W-1:0];
          CFG_MAX_BITS: max_bits_q <= cfg_data_i[BITS_W-1:0];
          CFG_TOL:      tol_q      <= cfg_data_i[BUCKET_W-1:0];
          CFG_TIMEOUT:  timeout_q  <= cfg_data_i[TICK_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      item_q <= in_item_i;
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import rclm_pkg::*;

  localparam int NSLOTS      = SLOTS_DEF;
  // The limit leaves a wide margin over the whole run, idling and stalls on
  // both sides included.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles allowed after the last result before registers are touched again.
  localparam int SETTLE      = NSLOTS + 10;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  int idle_pct = 38;
  int failures = 0;
  int cycles   = 0;

  // Items waiting for the driver, results waiting for the monitor, and the
  // frames offered for learning, which the random part replays to hit the table.
  in_item_t  items_to_send[$];
  out_item_t expected_outcomes[$];
  in_item_t  known_frames[$];

  // Our own copy of the registers and of the slot table.
  logic [BITS_W-1:0]   m_min_bits  = MIN_BITS_RST;
  logic [BITS_W-1:0]   m_max_bits  = MAX_BITS_RST;
  logic [BUCKET_W-1:0] m_tolerance = TOL_RST;
  logic [TICK_W-1:0]   m_timeout   = TIMEOUT_RST;

  logic [CODE_W-1:0]   m_code     [NSLOTS];
  logic [BITS_W-1:0]   m_bits     [NSLOTS];
  logic [BUCKET_W-1:0] m_bucket   [NSLOTS];
  logic                m_assigned [NSLOTS];
  logic                m_bound    [NSLOTS];
  logic                m_learning   = 1'b0;
  logic [SLOT_W-1:0]   m_target     = '0;
  logic                m_target_any = 1'b0;
  logic [TICK_W-1:0]   m_elapsed    = '0;

  remote_code_learn_match_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The lowest slot that no learn session has claimed yet, or -1.
  function automatic int first_unassigned();
    int i;
    for (i = 0; i < NSLOTS; i++)
      if (!m_assigned[i]) return i;
    return -1;
  endfunction

  // A bound slot hits a frame when code and bit count are equal and the
  // pulse buckets lie no further apart than the tolerance.
  function automatic bit slot_hits(int i, in_item_t f);
    int diff;
    if (!m_bound[i] || m_code[i] != f.code || m_bits[i] != f.bit_count) return 1'b0;
    diff = int'(m_bucket[i]) - int'(f.pulse_bucket);
    if (diff < 0) diff = -diff;
    return diff <= int'(m_tolerance);
  endfunction

  // Applies one item to our copy of the table and returns the result item
  // that the block has to give for it.
  function automatic out_item_t table_outcome(in_item_t it);
    out_item_t r;
    int        target;
    int        i;
    r = '0;
    r.status = ST_NOTHING;
    case (it.command)
      CMD_FRAME: begin
        if (it.bit_count < m_min_bits || it.bit_count > m_max_bits || it.code == '0) begin
          r.status = ST_INVALID;
        end else if (m_learning) begin
          if (m_target_any) target = first_unassigned();
          else if (int'(m_target) < NSLOTS) target = int'(m_target);
          else target = -1;
          if (target < 0) begin
            m_learning = 1'b0;
            r.status = ST_EXHAUSTED;
          end else begin
            // The target itself is left out: relearning a slot with its own
            // code is allowed.
            r.status = ST_LEARNED;
            for (i = 0; i < NSLOTS; i++)
              if (i != target && slot_hits(i, it)) r.status = ST_ALREADY;
            if (r.status == ST_LEARNED) begin
              m_assigned[target] = 1'b1;
              m_bound[target]    = 1'b1;
              m_code[target]     = it.code;
              m_bits[target]     = it.bit_count;
              m_bucket[target]   = it.pulse_bucket;
              m_learning         = 1'b0;
              r.result_slot      = SLOT_W'(target);
            end
          end
        end else begin
          // Scanning downward leaves the lowest hit in place.
          r.status = ST_NO_MATCH;
          for (i = NSLOTS - 1; i >= 0; i--)
            if (slot_hits(i, it)) begin
              r.status      = ST_MATCHED;
              r.result_slot = SLOT_W'(i);
            end
        end
      end
      CMD_START: begin
        if (it.any_slot) begin
          r.status = (first_unassigned() < 0) ? ST_EXHAUSTED : ST_STARTED;
        end else if (int'(it.slot_index) >= NSLOTS || !m_assigned[it.slot_index]) begin
          r.status = ST_UNKNOWN;
        end else begin
          r.status = ST_STARTED;
        end
        // A refused start leaves any running session as it was.
        if (r.status == ST_STARTED) begin
          m_learning   = 1'b1;
          m_target_any = it.any_slot;
          m_target     = it.any_slot ? '0 : it.slot_index;
          m_elapsed    = '0;
        end
      end
      CMD_CANCEL: begin
        m_learning = 1'b0;
        r.status   = ST_CANCELLED;
      end
      CMD_UNBIND: begin
        if (int'(it.slot_index) >= NSLOTS || !m_assigned[it.slot_index]) begin
          r.status = ST_UNKNOWN;
        end else begin
          m_bound[it.slot_index]  = 1'b0;
          m_code[it.slot_index]   = '0;
          m_bits[it.slot_index]   = '0;
          m_bucket[it.slot_index] = '0;
          r.status = ST_UNBOUND;
        end
      end
      CMD_TICK: begin
        if (m_learning) begin
          if (m_elapsed != '1) m_elapsed = m_elapsed + 1'b1;
          if (m_elapsed >= m_timeout) begin
            m_learning = 1'b0;
            r.status   = ST_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
    r.learn_active = m_learning;
    for (i = 0; i < NSLOTS; i++) begin
      r.assigned_count = r.assigned_count + SLOT_W'(m_assigned[i]);
      r.bound_count    = r.bound_count + SLOT_W'(m_bound[i]);
    end
    return r;
  endfunction

  // Driver: presents the next item unless it idles this cycle, and holds a
  // stalled item unchanged. Every accepted item is predicted right away.
  always @(posedge clk) begin : feed_items
    if (rst_n) begin
      if (in_valid && !in_stall) expected_outcomes.push_back(table_outcome(in_item));
      if (!in_valid || !in_stall) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= items_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and
  // stalls the block at random.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          $error("result item with none expected: status %0d", out_item.status);
          failures++;
        end else begin
          want = expected_outcomes.pop_front();
          if (out_item.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            failures++;
          end
          if (out_item.result_slot != want.result_slot) begin
            $error("result_slot: expected %0d, got %0d", want.result_slot,
                   out_item.result_slot);
            failures++;
          end
          if (out_item.learn_active != want.learn_active) begin
            $error("learn_active: expected %0d, got %0d", want.learn_active,
                   out_item.learn_active);
            failures++;
          end
          if (out_item.assigned_count != want.assigned_count) begin
            $error("assigned_count: expected %0d, got %0d", want.assigned_count,
                   out_item.assigned_count);
            failures++;
          end
          if (out_item.bound_count != want.bound_count) begin
            $error("bound_count: expected %0d, got %0d", want.bound_count,
                   out_item.bound_count);
            failures++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Writes one register; our copy follows once the write has been taken.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MIN_BITS: m_min_bits  = value[BITS_W-1:0];
      CFG_MAX_BITS: m_max_bits  = value[BITS_W-1:0];
      CFG_TOL:      m_tolerance = value[BUCKET_W-1:0];
      CFG_TIMEOUT:  m_timeout   = value[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_item(logic [CMD_W-1:0] cmd, logic [CODE_W-1:0] code, int bits,
                            int bucket, int idx, bit any);
    in_item_t it;
    it.command      = cmd;
    it.code         = code;
    it.bit_count    = BITS_W'(bits);
    it.pulse_bucket = BUCKET_W'(bucket);
    it.slot_index   = SLOT_W'(idx);
    it.any_slot     = any;
    items_to_send.push_back(it);
  endtask

  // Adds one random operation. Most are meaningful: replays of learned
  // frames with jittered buckets, and whole learn sessions (start, a few
  // ticks, a frame). The rest are single items of a random kind and fields.
  task automatic add_random_op();
    in_item_t it;
    in_item_t f;
    int       pick;
    int       span;
    int       b;
    it.command      = CMD_FRAME;
    it.code         = $urandom;
    it.bit_count    = BITS_W'($urandom_range(63));
    it.pulse_bucket = BUCKET_W'($urandom_range(255));
    it.slot_index   = SLOT_W'($urandom_range(15));
    it.any_slot     = $urandom_range(1) != 0;
    pick = $urandom_range(99);
    if (pick < 32 && known_frames.size() != 0) begin
      f = known_frames[$urandom_range(known_frames.size() - 1)];
      it.code = f.code;
      if ($urandom_range(7) != 0) it.bit_count = f.bit_count;
      // Jitter reaches just past the tolerance on both sides.
      span = int'(m_tolerance) + 2;
      b = int'(f.pulse_bucket) + int'($urandom_range(2 * span)) - span;
      it.pulse_bucket = BUCKET_W'((b < 0) ? 0 : (b > 255) ? 255 : b);
    end else if (pick < 42) begin
      if ($urandom_range(5) == 0) it.code = '0;
    end else if (pick < 62) begin
      it.command    = CMD_START;
      it.slot_index = SLOT_W'($urandom_range(NSLOTS - 1));
      items_to_send.push_back(it);
      f = it;
      f.command = CMD_TICK;
      repeat ($urandom_range(2)) items_to_send.push_back(f);
      it.command   = CMD_FRAME;
      it.bit_count = BITS_W'($urandom_range(int'(m_max_bits), int'(m_min_bits)));
      if ($urandom_range(4) == 0 && known_frames.size() != 0) begin
        // Learning a frame that may already be bound elsewhere.
        f = known_frames[$urandom_range(known_frames.size() - 1)];
        it.code         = f.code;
        it.bit_count    = f.bit_count;
        it.pulse_bucket = f.pulse_bucket;
      end else begin
        known_frames.push_back(it);
        if (known_frames.size() > 16) void'(known_frames.pop_front());
      end
    end else if (pick < 70) begin
      it.command = CMD_START;
    end else if (pick < 76) begin
      it.command = CMD_CANCEL;
    end else if (pick < 86) begin
      it.command    = CMD_UNBIND;
      it.slot_index = SLOT_W'($urandom_range(11));
    end else if (pick < 97) begin
      it.command = CMD_TICK;
    end else begin
      it.command = CMD_W'(5 + $urandom_range(2));
    end
    items_to_send.push_back(it);
  endtask

  // Waits until every item is sent and every result has come back, then
  // gives the block time to settle.
  task automatic wait_drained();
    while (items_to_send.size() != 0 || in_valid || expected_outcomes.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_phase(int min_b, int max_b, int tol, logic [TICK_W-1:0] timeout,
                           int n_items, int idle);
    write_register(CFG_MIN_BITS, CFG_DAT_W'(min_b));
    write_register(CFG_MAX_BITS, CFG_DAT_W'(max_b));
    write_register(CFG_TOL, CFG_DAT_W'(tol));
    write_register(CFG_TIMEOUT, timeout);
    idle_pct = idle;
    while (items_to_send.size() < n_items) add_random_op();
    wait_drained();
  endtask

  initial begin : stimulus
    in_item_t a;
    int       i;
    for (i = 0; i < NSLOTS; i++) begin
      m_code[i]     = '0;
      m_bits[i]     = '0;
      m_bucket[i]   = '0;
      m_assigned[i] = 1'b0;
      m_bound[i]    = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset limits (16 to 32 bits, tolerance 3), with a
    // short timeout so that a session can run out.
    write_register(CFG_TIMEOUT, 2);
    queue_item(CMD_FRAME, 32'h0, 20, 9, 0, 1'b0);            // zero code
    queue_item(CMD_FRAME, 32'h1, 15, 9, 0, 1'b0);            // one bit short
    queue_item(CMD_FRAME, 32'h1, 33, 9, 0, 1'b0);            // one bit too long
    queue_item(CMD_FRAME, 32'hFFFF_FFFF, 16, 0, 0, 1'b0);    // empty table
    queue_item(CMD_START, 32'h0, 0, 0, 0, 1'b0);             // slot not assigned
    queue_item(CMD_START, 32'h0, 0, 0, 15, 1'b0);            // slot out of range
    queue_item(CMD_UNBIND, 32'h0, 0, 0, 12, 1'b0);
    queue_item(CMD_UNBIND, 32'h0, 0, 0, 4, 1'b0);
    queue_item(CMD_START, 32'h0, 0, 0, 0, 1'b1);
    queue_item(CMD_TICK, 32'h0, 0, 0, 0, 1'b0);
    queue_item(CMD_TICK, 32'h0, 0, 0, 0, 1'b0);              // session times out
    queue_item(CMD_START, 32'h0, 0, 0, 0, 1'b1);
    queue_item(CMD_FRAME, 32'hA5A5_0F0F, 32, 255, 0, 1'b0);  // learned into slot 0
    queue_item(CMD_FRAME, 32'hA5A5_0F0F, 32, 252, 0, 1'b0);  // edge of tolerance
    queue_item(CMD_FRAME, 32'hA5A5_0F0F, 32, 251, 0, 1'b0);  // just outside
    queue_item(CMD_FRAME, 32'hA5A5_0F0F, 31, 255, 0, 1'b0);  // bit count differs
    queue_item(CMD_START, 32'h0, 0, 0, 0, 1'b1);
    queue_item(CMD_FRAME, 32'hA5A5_0F0F, 32, 254, 0, 1'b0);  // bound elsewhere
    queue_item(CMD_CANCEL, 32'h0, 0, 0, 0, 1'b0);
    queue_item(CMD_START, 32'h0, 0, 0, 0, 1'b0);
    queue_item(CMD_FRAME, 32'hA5A5_0F0F, 32, 253, 0, 1'b0);  // relearn own slot
    queue_item(CMD_UNBIND, 32'h0, 0, 0, 0, 1'b0);
    queue_item(CMD_FRAME, 32'hA5A5_0F0F, 32, 253, 0, 1'b0);  // unbound now
    queue_item(CMD_W'(7), 32'h0, 0, 0, 0, 1'b0);
    queue_item(CMD_TICK, 32'h0, 0, 0, 0, 1'b0);              // tick while idle
    a = items_to_send[12];
    known_frames.push_back(a);
    wait_drained();

    // Random part over several register settings. The second phase runs
    // without any idling or stalls.
    run_phase(8, 32, 3, 3, 250, 38);
    run_phase(1, 32, 0, 1, 200, 0);
    run_phase(32, 32, 255, 32'hFFFF_FFFF, 200, 38);
    run_phase(20, 24, 12, 6, 200, 38);

    if (failures == 0 && expected_outcomes.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
